FILE: rtl/core/vmd_pkg.sv
// Shared widths, types and the sine table builder for the vibrato delay block.
`timescale 1ns / 1ps
`default_nettype none

package vmd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int DEPTH_BITS     = 10;
  localparam int DELAY_BITS     = 11;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ENTRIES   = 1024;
  localparam int SINE_BITS      = $clog2(SINE_ENTRIES);
  localparam int SINE_W         = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // Q15 polynomial coefficients of the quarter-wave sine
  localparam longint SinA   = 51472;
  localparam longint SinB   = 21024;
  localparam longint SinC   = 2320;
  localparam longint Q15One = 32768;
  localparam longint Q15Max = 32767;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DEPTH = 2'd0,
    CFG_STEP  = 2'd1
  } cfg_index_t;

  typedef logic signed [SINE_W-1:0] sine_t;
  typedef sine_t sine_rom_t [SINE_ENTRIES];

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [DELAY_BITS-1:0]         delay;
  } frame_t;

  typedef struct packed {
    logic load;     // request taken into the first stage
    logic advance;  // first stage moves into the store read stage
  } pipe_ctrl_t;

  function automatic longint quarter_sine(longint x);
    longint xx;
    longint inner;
    longint mid;
    longint y;
    xx    = (x * x) >> 15;
    inner = SinB - ((SinC * xx) >> 15);
    mid   = SinA - ((xx * inner) >> 15);
    y     = (x * mid) >> 15;
    if (y > Q15Max) begin
      y = Q15Max;
    end
    return y;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    four_k;
    longint    x;
    longint    mag;
    longint    quad;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      four_k = 4 * longint'(k);
      quad   = (four_k / SINE_ENTRIES) & 3;
      x      = ((four_k % SINE_ENTRIES) << 15) / SINE_ENTRIES;
      mag    = ((quad & 1) != 0) ? quarter_sine(Q15One - x) : quarter_sine(x);
      rom[k] = ((quad & 2) != 0) ? SINE_W'(-mag) : SINE_W'(mag);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vmd_lfo.sv
// Sine LFO: phase accumulator, registered sine table read and delay computation.
`timescale 1ns / 1ps
`default_nettype none

module vmd_lfo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire logic [vmd_pkg::PHASE_BITS-1:0]  phase_step,
  input  wire logic [vmd_pkg::DEPTH_BITS-1:0]  depth_samples,
  output logic      [vmd_pkg::DELAY_BITS-1:0]  delay
);
  import vmd_pkg::*;

  localparam sine_rom_t SineRom = build_sine_rom();

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  sine_t                 sine;
  logic signed [26:0]    prod;
  logic signed [27:0]    acc;

  assign phase_next = phase + phase_step;

  // sine always matches the current phase, so the delay is ready at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      sine  <= '0;
    end else if (advance) begin
      phase <= phase_next;
      sine  <= SineRom[phase_next[PHASE_BITS-1 -: SINE_BITS]];
    end
  end

  always_comb begin
    prod  = $signed({1'b0, depth_samples}) * sine;
    acc   = $signed({2'b00, depth_samples, 16'h0000}) + {prod[26], prod};
    delay = acc[26:16];
  end

endmodule

`default_nettype wire

FILE: rtl/core/vmd_line.sv
// Circular stereo store with write pointer, lap tracking and tap read stage.
`timescale 1ns / 1ps
`default_nettype none

module vmd_line #(
  parameter int DELAY_DEPTH = 2048
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire vmd_pkg::pipe_ctrl_t                    ctrl,
  input  wire logic signed [vmd_pkg::SAMPLE_BITS-1:0] sample_left,
  input  wire logic signed [vmd_pkg::SAMPLE_BITS-1:0] sample_right,
  input  wire logic        [vmd_pkg::DELAY_BITS-1:0]  delay_in,
  output vmd_pkg::frame_t                             frame
);
  import vmd_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int EW = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
  localparam logic [EW-1:0] DepthE   = EW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DELAY_DEPTH - 1);

  logic [AW-1:0] wp;
  logic          lapped;

  logic signed [SAMPLE_BITS-1:0] s1_left;
  logic signed [SAMPLE_BITS-1:0] s1_right;
  logic [DELAY_BITS-1:0]         s1_delay;
  logic [AW-1:0]                 s1_wp;
  logic                          s1_lapped;

  logic [2*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic [DELAY_BITS-1:0]    s2_delay;
  logic                     s2_hit;

  logic [EW-1:0] delay_e;
  logic [EW-1:0] dmod_e;
  logic [EW-1:0] wp_e;
  logic [EW-1:0] rp_e;
  logic [AW-1:0] rp;
  logic          hit;

  // Write pointer; lapped marks that every slot has been written once
  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      lapped <= 1'b0;
    end else if (ctrl.load) begin
      wp     <= (wp == LastSlot) ? '0 : wp + 1'b1;
      lapped <= lapped | (wp == LastSlot);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s1_left   <= sample_left;
      s1_right  <= sample_right;
      s1_delay  <= delay_in;
      s1_wp     <= wp;
      s1_lapped <= lapped;
    end
  end

  // Wrap the delay into the store, then step back from the write slot
  always_comb begin
    delay_e = EW'(s1_delay);
    dmod_e  = (delay_e >= DepthE) ? delay_e - DepthE : delay_e;
    wp_e    = EW'(s1_wp);
    rp_e    = (wp_e >= dmod_e) ? wp_e - dmod_e : wp_e + DepthE - dmod_e;
    rp      = rp_e[AW-1:0];
    hit     = s1_lapped || (rp < s1_wp);
  end

  // Read before write: a zero delay returns the oldest sample in the slot
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      rd_data    <= mem[rp];
      mem[s1_wp] <= {s1_left, s1_right};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      s2_delay <= s1_delay;
      s2_hit   <= hit;
    end
  end

  always_comb begin
    frame.left  = s2_hit ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    frame.right = s2_hit ? rd_data[SAMPLE_BITS-1:0] : '0;
    frame.delay = s2_delay;
  end

endmodule

`default_nettype wire

FILE: rtl/core/vmd_flow.sv
// Stage valid tracking, stall generation and the output register.
`timescale 1ns / 1ps
`default_nettype none

module vmd_flow (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                out_stall,
  input  wire vmd_pkg::frame_t     frame_in,
  output logic                     in_stall,
  output vmd_pkg::pipe_ctrl_t      ctrl,
  output logic                     out_valid,
  output vmd_pkg::frame_t          frame_out
);
  import vmd_pkg::*;

  logic v1;
  logic v2;
  logic move_out;

  always_comb begin
    move_out     = v2 && (!out_valid || !out_stall);
    ctrl.advance = v1 && (!v2 || move_out);
    ctrl.load    = in_valid && (!v1 || ctrl.advance);
    in_stall     = v1 && !ctrl.advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= ctrl.load || (v1 && !ctrl.advance);
      v2        <= ctrl.advance || (v2 && !move_out);
      out_valid <= move_out || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      frame_out <= frame_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vibrato_modulated_delay_top.sv
// Top level of the stereo vibrato: sine-swept delay line with valid/stall channels.
// Path: input stage, store read stage (tap read and frame write), output register.
// Throughput: one stereo frame per cycle while the output is not stalled; the store's
//   one write and one read port are both used on each stage advance, and the two
//   inner stages keep taking requests while a result waits, until both are full.
// Reset: clears pointers, LFO phase, configuration registers and stage valids; the
//   store is not swept, a lap flag makes never-written slots read as zero.
`timescale 1ns / 1ps
`default_nettype none

module vibrato_modulated_delay_top #(
  parameter int DELAY_DEPTH = 2048
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // configuration write port
  input  wire logic                                     cfg_we,
  input  wire logic        [vmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic        [vmd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic signed [vmd_pkg::SAMPLE_BITS-1:0]   sample_left,
  input  wire logic signed [vmd_pkg::SAMPLE_BITS-1:0]   sample_right,
  // output channel
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic signed      [vmd_pkg::SAMPLE_BITS-1:0]   out_left,
  output logic signed      [vmd_pkg::SAMPLE_BITS-1:0]   out_right,
  output logic             [vmd_pkg::DELAY_BITS-1:0]    delay_used
);
  import vmd_pkg::*;

  logic [DEPTH_BITS-1:0] depth_samples;
  logic [PHASE_BITS-1:0] phase_step;
  logic [DELAY_BITS-1:0] delay;
  pipe_ctrl_t            ctrl;
  frame_t                line_frame;
  frame_t                out_frame;

  // Configuration registers: mask to field width, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_samples <= '0;
      phase_step    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEPTH: depth_samples <= cfg_data[DEPTH_BITS-1:0];
        CFG_STEP:  phase_step    <= cfg_data[PHASE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Delay for the next request comes from the phase in effect before it;
  // advance the phase on each accepted request.
  vmd_lfo u_lfo (
    .clk           (clk),
    .rst           (rst),
    .advance       (ctrl.load),
    .phase_step    (phase_step),
    .depth_samples (depth_samples),
    .delay         (delay)
  );

  // Hold the request for one stage, then read the tap and write the new frame
  // in the same cycle.
  vmd_line #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .delay_in     (delay),
    .frame        (line_frame)
  );

  // Stage valids and the output register; stall only when every stage is full.
  vmd_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .frame_in  (line_frame),
    .in_stall  (in_stall),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .frame_out (out_frame)
  );

  assign out_left   = out_frame.left;
  assign out_right  = out_frame.right;
  assign delay_used = out_frame.delay;

endmodule

`default_nettype wire

FILE: rtl/core/vmd_checker.sv
// Port-level checks for the vibrato delay top level, bound to it below.
`timescale 1ns / 1ps
`default_nettype none

module vmd_checker (
  input wire logic                                     clk,
  input wire logic                                     rst,
  input wire logic                                     in_valid,
  input wire logic                                     in_stall,
  input wire logic signed [vmd_pkg::SAMPLE_BITS-1:0]   sample_left,
  input wire logic signed [vmd_pkg::SAMPLE_BITS-1:0]   sample_right,
  input wire logic                                     out_valid,
  input wire logic                                     out_stall,
  input wire logic signed [vmd_pkg::SAMPLE_BITS-1:0]   out_left,
  input wire logic signed [vmd_pkg::SAMPLE_BITS-1:0]   out_right,
  input wire logic        [vmd_pkg::DELAY_BITS-1:0]    delay_used
);
  import vmd_pkg::*;

  localparam logic [DELAY_BITS-1:0] MaxDelay = DELAY_BITS'(1534);

  // Input backs up only when a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  // A stalled request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(sample_left) &&
                                $stable(sample_right)))
    else $error("stalled request changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left) &&
                                  $stable(out_right) && $stable(delay_used)))
    else $error("stalled result changed");

  // Delay never exceeds one and a half times the largest depth
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delay_used <= MaxDelay))
    else $error("delay out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

bind vibrato_modulated_delay_top vmd_checker u_vmd_checker (.*);

`default_nettype wire
